/* rtl/fvn_pkg.sv */
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared constants, register map and sequencer states of the 2-D fractal
// value noise generator.
// ----------------------------------------------------------------------------
package fvn_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_OCTAVES_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // configuration register map (word index)
  localparam logic [1:0] REG_FREQUENCY = 2'd0;
  localparam logic [1:0] REG_OCTAVES   = 2'd1;
  localparam logic [1:0] REG_HASH_SEED = 2'd2;

  localparam logic [31:0] FREQUENCY_RST = 32'd6554;
  localparam logic [4:0]  OCTAVES_RST   = 5'd4;
  localparam logic [7:0]  HASH_SEED_RST = 8'd0;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int QUOT_BITS = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULY,
    ST_MULX,
    ST_LDX,
    ST_SQX,
    ST_CUBX,
    ST_SQY,
    ST_CUBY,
    ST_BLX0,
    ST_BLX1,
    ST_BLY0,
    ST_BLY1,
    ST_BLZ0,
    ST_BLZ1,
    ST_ACC,
    ST_DIV
  } fvn_state_t;

endpackage

/* rtl/fractal_value_noise_2d.sv */
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// Fractal 2-D value noise: byte lattice table, smoothstep blending, octave
// sum and normalization to unsigned Q0.16.
// ----------------------------------------------------------------------------
// A load command (op=0) writes one table byte in the cycle it is taken and
// leaves busy low. A sample command (op=1) raises busy while the MULY, MULX
// and LDX states scale the coordinates, each octave (up to the clamped octave
// count) makes its passes through the single shared multiplier while the six
// hashed table reads overlap them, and a 16-step restoring divider normalizes
// the sum. done pulses for one cycle with noise_value valid; the receiver
// cannot stall, so capture it then. Table entries read by a sample must have
// been loaded first.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d #(
  parameter int TABLE_DEPTH = fvn_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op,
  input  logic [15:0]            coord_x,
  input  logic [15:0]            coord_y,
  input  logic [7:0]             entry_index,
  input  logic [7:0]             entry_value,
  output logic                   done,
  output logic [15:0]            noise_value,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import fvn_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int F   = FRAC_BITS;
  localparam int MW  = F + 8;
  localparam int PW  = 2 * MW;
  localparam int MO  = MAX_OCTAVES;
  localparam int TW  = F + 8 + MO;
  localparam int NW  = QUOT_BITS + MO;
  localparam int PSW = F + AW;
  localparam logic [F:0]   ONE       = (F + 1)'(1) << F;
  localparam logic [F+1:0] THREE_ONE = (F + 2)'(3) << F;

  // configuration
  logic [MW-1:0] frequency;
  logic [4:0]    octaves;
  logic [7:0]    hash_seed;
  logic          cfg_wr;
  logic [1:0]    reg_idx;

  // sequencer and datapath
  fvn_state_t       state, state_next;
  logic [15:0]      x_in, y_in;
  logic [PSW-1:0]   pos_x, pos_y;
  logic [4:0]       oct;
  logic [4:0]       depth;
  logic [F:0]       wx, wy;
  logic [7:0]       f0, f1, c00, c10, c01, c11;
  logic [F+7:0]     low, high;
  logic [TW-1:0]    total, total_next;
  logic [MO-1:0]    r_div;
  logic [15:0]      q_div;
  logic [3:0]       div_cnt;
  logic [MO-1:0]    divisor;
  logic [MO:0]      one_shl;
  logic [MO:0]      dtrial, dsub;
  logic             dge;
  logic [MO-1:0]    r_next;
  logic [NW-1:0]    numer;

  logic [MW-1:0]    mac_a, mac_b;
  logic             mac_acc;
  logic [PW-1:0]    prod;

  logic [AW-1:0]    cx, cy, nx, ny;
  logic [F-1:0]     sx, sy;
  logic [F-1:0]     sq;
  logic [F+1:0]     tx, ty;
  logic [F:0]       omw_x, omw_y;
  logic [AW+7:0]    sum_cy, sum_ny, sum_f0cx, sum_f0nx, sum_f1cx, sum_f1nx;
  logic [AW+7:0]    widx;
  logic             we;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency <= MW'(FREQUENCY_RST);
      octaves   <= OCTAVES_RST;
      hash_seed <= HASH_SEED_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FREQUENCY: frequency <= pwdata[MW-1:0];
        REG_OCTAVES:   octaves   <= pwdata[4:0];
        REG_HASH_SEED: hash_seed <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FREQUENCY: prdata = 32'(frequency);
      REG_OCTAVES:   prdata = 32'(octaves);
      REG_HASH_SEED: prdata = 32'(hash_seed);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    if (octaves == 5'd0) begin
      depth = 5'd1;
    end else if (octaves > 5'(MO)) begin
      depth = 5'(MO);
    end else begin
      depth = octaves;
    end
  end

  // table load port
  assign widx = (AW + 8)'(entry_index);
  assign we   = start && !busy && (op == OP_LOAD) && (widx < (AW + 8)'(TABLE_DEPTH));

  fvn_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (widx[AW-1:0]),
    .wdata (entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  fvn_mac #(
    .MW (MW)
  ) u_mac (
    .clk        (clk),
    .op_a       (mac_a),
    .op_b       (mac_b),
    .accumulate (mac_acc),
    .prod       (prod)
  );

  // lattice position and fractions
  assign cx    = pos_x[PSW-1:F];
  assign cy    = pos_y[PSW-1:F];
  assign nx    = cx + AW'(1);
  assign ny    = cy + AW'(1);
  assign sx    = pos_x[F-1:0];
  assign sy    = pos_y[F-1:0];
  assign sq    = prod[2*F-1:F];
  assign tx    = THREE_ONE - {1'b0, sx, 1'b0};
  assign ty    = THREE_ONE - {1'b0, sy, 1'b0};
  assign omw_x = ONE - wx;
  assign omw_y = ONE - wy;

  // double hash addresses
  assign sum_cy   = (AW + 8)'(cy) + (AW + 8)'(hash_seed);
  assign sum_ny   = (AW + 8)'(ny) + (AW + 8)'(hash_seed);
  assign sum_f0cx = (AW + 8)'(f0) + (AW + 8)'(cx);
  assign sum_f0nx = (AW + 8)'(f0) + (AW + 8)'(nx);
  assign sum_f1cx = (AW + 8)'(f1) + (AW + 8)'(cx);
  assign sum_f1nx = (AW + 8)'(f1) + (AW + 8)'(nx);

  // octave accumulation (Horner form of the weighted sum) and divider
  assign total_next = {total[TW-2:0], 1'b0} + TW'(prod[2*F+7:F]);
  assign numer      = total_next[TW-1:F-8];
  assign one_shl    = (MO + 1)'(1) << depth;
  assign divisor    = MO'(one_shl - (MO + 1)'(1));
  assign dtrial     = {r_div, q_div[15]};
  assign dge        = dtrial >= {1'b0, divisor};
  assign dsub       = dtrial - {1'b0, divisor};
  assign r_next     = dge ? dsub[MO-1:0] : dtrial[MO-1:0];

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_a      = '0;
    mac_b      = '0;
    mac_acc    = 1'b0;
    raddr      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start && op == OP_SAMPLE) begin
          state_next = ST_MULY;
        end
      end
      ST_MULY: begin
        mac_a      = MW'(y_in);
        mac_b      = frequency;
        state_next = ST_MULX;
      end
      ST_MULX: begin
        mac_a      = MW'(x_in);
        mac_b      = frequency;
        state_next = ST_LDX;
      end
      ST_LDX: begin
        state_next = ST_SQX;
      end
      ST_SQX: begin
        mac_a      = MW'(sx);
        mac_b      = MW'(sx);
        raddr      = sum_cy[AW-1:0];
        state_next = ST_CUBX;
      end
      ST_CUBX: begin
        mac_a      = MW'(sq);
        mac_b      = MW'(tx);
        raddr      = sum_ny[AW-1:0];
        state_next = ST_SQY;
      end
      ST_SQY: begin
        mac_a      = MW'(sy);
        mac_b      = MW'(sy);
        raddr      = sum_f0cx[AW-1:0];
        state_next = ST_CUBY;
      end
      ST_CUBY: begin
        mac_a      = MW'(sq);
        mac_b      = MW'(ty);
        raddr      = sum_f0nx[AW-1:0];
        state_next = ST_BLX0;
      end
      ST_BLX0: begin
        mac_a      = MW'(c00);
        mac_b      = MW'(omw_x);
        raddr      = sum_f1cx[AW-1:0];
        state_next = ST_BLX1;
      end
      ST_BLX1: begin
        mac_a      = MW'(c10);
        mac_b      = MW'(wx);
        mac_acc    = 1'b1;
        raddr      = sum_f1nx[AW-1:0];
        state_next = ST_BLY0;
      end
      ST_BLY0: begin
        mac_a      = MW'(c01);
        mac_b      = MW'(omw_x);
        state_next = ST_BLY1;
      end
      ST_BLY1: begin
        mac_a      = MW'(c11);
        mac_b      = MW'(wx);
        mac_acc    = 1'b1;
        state_next = ST_BLZ0;
      end
      ST_BLZ0: begin
        mac_a      = MW'(low);
        mac_b      = MW'(omw_y);
        state_next = ST_BLZ1;
      end
      ST_BLZ1: begin
        mac_a      = MW'(high);
        mac_b      = MW'(wy);
        mac_acc    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (oct == depth - 5'd1) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_SQX;
        end
      end
      ST_DIV: begin
        if (div_cnt == 4'd15) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DIV) && (div_cnt == 4'd15);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x_in <= coord_x;
        y_in <= coord_y;
      end
      ST_MULX: pos_y <= prod[PSW-1:0];
      ST_LDX: begin
        pos_x <= prod[PSW-1:0];
        total <= '0;
        oct   <= '0;
      end
      ST_CUBX: f0 <= rdata;
      ST_SQY: begin
        wx <= prod[2*F:F];
        f1 <= rdata;
      end
      ST_CUBY: c00 <= rdata;
      ST_BLX0: begin
        wy  <= prod[2*F:F];
        c10 <= rdata;
      end
      ST_BLX1: c01 <= rdata;
      ST_BLY0: begin
        c11 <= rdata;
        low <= prod[F+7:0];
      end
      ST_BLZ0: high <= prod[F+7:0];
      ST_ACC: begin
        total   <= total_next;
        pos_x   <= {pos_x[PSW-2:0], 1'b0};
        pos_y   <= {pos_y[PSW-2:0], 1'b0};
        oct     <= oct + 5'd1;
        r_div   <= numer[NW-1:QUOT_BITS];
        q_div   <= numer[QUOT_BITS-1:0];
        div_cnt <= '0;
      end
      ST_DIV: begin
        r_div   <= r_next;
        q_div   <= {q_div[14:0], dge};
        div_cnt <= div_cnt + 4'd1;
        if (div_cnt == 4'd15) begin
          noise_value <= {q_div[14:0], dge};
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/fvn_ram.sv */
// ----------------------------------------------------------------------------
// fvn_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fvn_mac.sv */
// ----------------------------------------------------------------------------
// fvn_mac
// Shared multiply-accumulate unit with a registered product.
// ----------------------------------------------------------------------------
module fvn_mac #(
  parameter int MW = 24
) (
  input  logic            clk,
  input  logic [MW-1:0]   op_a,
  input  logic [MW-1:0]   op_b,
  input  logic            accumulate,
  output logic [2*MW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= (accumulate ? prod : '0) + ((2*MW)'(op_a) * (2*MW)'(op_b));
  end

endmodule

/* test/fractal_value_noise_2d_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_test
// Self-checking bench for the 2-D fractal value noise block. Loads the lattice
// table, runs directed and random sample commands under several register
// settings and idle patterns, and compares every noise value with an in-bench
// fixed-point predictor.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d_test;
  import fvn_pkg::*;

  localparam int          FB        = 16;
  localparam longint      ONE       = 64'd1 << FB;
  localparam longint      CYC_LIMIT = 3000000;
  localparam int          SETTLE    = 16;
  localparam logic [3:0]  ADDR_NONE = 4'd12; // past the register list

  typedef struct {
    logic        op;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  idx;
    logic [7:0]  val;
  } noise_cmd_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        op = 0;
  logic [15:0] coord_x = 0;
  logic [15:0] coord_y = 0;
  logic [7:0]  entry_index = 0;
  logic [7:0]  entry_value = 0;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic        busy, done, pready;
  logic [15:0] noise_value;
  logic [31:0] prdata;

  fractal_value_noise_2d DUT (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [7:0]  lattice_bytes [256];
  logic [23:0] freq_q = FREQUENCY_RST[23:0];
  logic [4:0]  octave_cnt = OCTAVES_RST;
  logic [7:0]  seed_q = HASH_SEED_RST;

  noise_cmd_t  cmd_fifo [$];
  logic [15:0] noise_fifo [$];
  noise_cmd_t  cur;
  int          idle_pct = 0;
  int          err_count = 0;
  int          n_loads = 0, n_samples = 0, n_checked = 0;
  longint      cycles = 0;

  function automatic longint smooth_weight(longint s);
    longint sq;
    sq = (s * s) >> FB;
    return (sq * (3 * ONE - 2 * s)) >> FB;
  endfunction

  function automatic longint lerp_fx(longint a, longint b, longint w);
    return (a * (ONE - w) + b * w) >> FB;
  endfunction

  function automatic longint hashed_corner(logic [7:0] col, logic [7:0] row);
    logic [7:0] first;
    first = lattice_bytes[8'(row + seed_q)];
    return longint'(lattice_bytes[8'(first + col)]) << FB;
  endfunction

  function automatic longint octave_level(longint px, longint py);
    logic [7:0] cx, cy;
    longint wx, wy, lo, hi;
    cx = 8'(px >> FB);
    cy = 8'(py >> FB);
    wx = smooth_weight(px & (ONE - 1));
    wy = smooth_weight(py & (ONE - 1));
    lo = lerp_fx(hashed_corner(cx, cy), hashed_corner(8'(cx + 1), cy), wx);
    hi = lerp_fx(hashed_corner(cx, 8'(cy + 1)), hashed_corner(8'(cx + 1), 8'(cy + 1)), wx);
    return lerp_fx(lo, hi, wy);
  endfunction

  function automatic logic [15:0] predict_noise(logic [15:0] x, logic [15:0] y);
    int     d;
    longint bx, by, total, den, q, r;
    d = octave_cnt;
    if (d < 1) d = 1;
    if (d > 16) d = 16;
    bx = longint'(x) * longint'(freq_q);
    by = longint'(y) * longint'(freq_q);
    total = 0;
    for (int i = 0; i < d; i++)
      total += octave_level(bx << i, by << i) << (d - 1 - i);
    den = ONE * ((64'd1 << d) - 1);
    q = total / den;
    r = total % den;
    return 16'(q * 256 + (r * 256) / den);
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // driver: one command presented at a time, held until taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        if (cur.op == OP_LOAD) begin
          lattice_bytes[cur.idx] = cur.val;
          n_loads++;
        end else begin
          noise_fifo.push_back(predict_noise(cur.x, cur.y));
          n_samples++;
        end
      end
      if (!start || !busy) begin
        if (cmd_fifo.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur = cmd_fifo.pop_front();
          op <= cur.op;
          coord_x <= cur.x;
          coord_y <= cur.y;
          entry_index <= cur.idx;
          entry_value <= cur.val;
          start <= 1;
        end else begin
          start <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (noise_fifo.size() == 0) begin
        report_error($sformatf("unexpected result noise_value=%h", noise_value));
      end else begin
        logic [15:0] want;
        want = noise_fifo.pop_front();
        n_checked++;
        if (noise_value !== want)
          report_error($sformatf("noise_value got %h want %h", noise_value, want));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    logic [31:0] want;
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    want = '0;
    if (addr == {REG_FREQUENCY, 2'b00}) begin
      freq_q = data[23:0];
      want = 32'(data[23:0]);
    end else if (addr == {REG_OCTAVES, 2'b00}) begin
      octave_cnt = data[4:0];
      want = 32'(data[4:0]);
    end else if (addr == {REG_HASH_SEED, 2'b00}) begin
      seed_q = data[7:0];
      want = 32'(data[7:0]);
    end
    // read back through the still-held address
    @(negedge clk);
    if (pready !== 1'b1)
      report_error("pready low");
    if (prdata !== want)
      report_error($sformatf("readback addr %h got %h want %h", addr, prdata, want));
  endtask

  task automatic push_cmd(logic o, logic [15:0] x, logic [15:0] y,
                          logic [7:0] idx, logic [7:0] val);
    noise_cmd_t c;
    c.op = o; c.x = x; c.y = y; c.idx = idx; c.val = val;
    cmd_fifo.push_back(c);
  endtask

  // wait until every issued transaction has been taken and answered
  task automatic drain();
    do @(negedge clk);
    while (cmd_fifo.size() > 0 || start || busy || noise_fifo.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_mix(int n);
    for (int i = 0; i < n; i++)
      push_cmd($urandom_range(99) < 20 ? OP_LOAD : OP_SAMPLE, 16'($urandom),
               16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int idle_pat [4] = '{0, 76, 0, 24};
    logic [31:0] f_set [7] = '{32'd6554, 32'hFF_FFFF, 32'd0, 32'd65536,
                               32'd1, 32'd0, 32'd300};
    logic [31:0] o_set [7] = '{32'd4, 32'd16, 32'd0, 32'd1, 32'd31, 32'd2, 32'd3};
    logic [31:0] s_set [7] = '{32'd0, 32'd255, 32'd1, 32'd0, 32'd128, 32'd77, 32'd200};
    repeat (4) @(posedge clk);
    rst <= 0;

    // fill the whole lattice table before any sample
    for (int i = 0; i < 256; i++)
      push_cmd(OP_LOAD, 16'($urandom), 16'($urandom), 8'(i), 8'($urandom));
    drain();

    // directed: coordinate extremes, load extremes
    push_cmd(OP_SAMPLE, 16'h0000, 16'h0000, 8'h00, 8'h00);
    push_cmd(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    push_cmd(OP_SAMPLE, 16'h0000, 16'hFFFF, 8'h00, 8'hFF);
    push_cmd(OP_SAMPLE, 16'hFFFF, 16'h0000, 8'hFF, 8'h00);
    push_cmd(OP_LOAD, 16'hFFFF, 16'h0000, 8'h00, 8'hFF);
    push_cmd(OP_LOAD, 16'h0000, 16'hFFFF, 8'hFF, 8'h00);
    push_cmd(OP_SAMPLE, 16'h5555, 16'hAAAA, 8'h55, 8'hAA);
    push_cmd(OP_LOAD, 16'hAAAA, 16'h5555, 8'h80, 8'h00);
    push_cmd(OP_SAMPLE, 16'h0001, 16'h8000, 8'h00, 8'h00);
    drain();
    // write past the register list; must not disturb anything
    reg_write(ADDR_NONE, 32'hFFFF_FFFF);
    push_cmd(OP_SAMPLE, 16'h1234, 16'h4321, 8'h00, 8'h00);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      reg_write({REG_FREQUENCY, 2'b00}, ph == 6 ? 32'($urandom) : f_set[ph]);
      reg_write({REG_OCTAVES, 2'b00}, o_set[ph]);
      reg_write({REG_HASH_SEED, 2'b00}, s_set[ph]);
      idle_pct = idle_pat[ph % 4];
      random_mix(ph == 1 || ph == 4 ? 40 : 90);
      drain();
    end

    $display("covered %0d table loads and %0d samples (%0d checked) over 7 settings",
             n_loads, n_samples, n_checked);
    $display("octave counts 0..31 incl. clamping, frequency and seed extremes");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
